[rtl/m3i_pkg.sv]
// ----------------------------------------------------------------------------
// m3i_pkg
// Types, widths and the cofactor table shared by the 3x3 inverse pipeline.
// ----------------------------------------------------------------------------
package m3i_pkg;

    localparam int ELEM_W     = 32;   // Q16.16 element
    localparam int NUM_ELEM   = 9;
    localparam int PROD_W     = 64;   // element product
    localparam int COF_W      = 65;   // signed cofactor, Q32.32
    localparam int CMAG_W     = 64;   // cofactor magnitude
    localparam int PLO_W      = 66;   // element times low cofactor half
    localparam int PHI_W      = 64;   // element times high cofactor half
    localparam int LO_SPLIT   = 33;   // bits in the low cofactor half
    localparam int PFULL_W    = 97;   // element times cofactor
    localparam int DET_W      = 99;   // signed determinant, Q48.48
    localparam int DMAG_W     = 98;   // determinant magnitude
    localparam int THR_W      = 31;
    localparam int THR_SHIFT  = 32;   // Q16.16 to Q48.48
    localparam int DIV_STEPS  = 31;   // quotient bits below the saturation point
    localparam int DIV_FIRST  = 8;    // first divider stage
    localparam int NUM_STAGES = DIV_FIRST + DIV_STEPS + 1;
    localparam int APB_AW     = 3;
    localparam int APB_DW     = 32;

    // Register index, taken from paddr[2].
    localparam logic REG_DET_THR = 1'b0;

    localparam logic [ELEM_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [ELEM_W-1:0] SAT_NEG = 32'h8000_0000;
    localparam logic [THR_W-1:0]  THR_RESET = 31'd1;

    // Cofactor k = m[a]*m[b] - m[c]*m[d], element (column c, row r) at 3c+r.
    localparam int COF_IDX [NUM_ELEM][4] = '{
        '{4, 8, 7, 5}, '{1, 8, 7, 2}, '{1, 5, 4, 2},
        '{3, 8, 6, 5}, '{0, 8, 6, 2}, '{0, 5, 3, 2},
        '{3, 7, 6, 4}, '{0, 7, 6, 1}, '{0, 4, 3, 1}
    };
    localparam logic [NUM_ELEM-1:0] COF_NEG = 9'b0_1010_1010;

    typedef logic signed [ELEM_W-1:0] t_elem;

    typedef struct packed {
        t_elem in_c0r0;
        t_elem in_c0r1;
        t_elem in_c0r2;
        t_elem in_c1r0;
        t_elem in_c1r1;
        t_elem in_c1r2;
        t_elem in_c2r0;
        t_elem in_c2r1;
        t_elem in_c2r2;
    } t_mat;

    typedef struct packed {
        t_elem inv_c0r0;
        t_elem inv_c0r1;
        t_elem inv_c0r2;
        t_elem inv_c1r0;
        t_elem inv_c1r1;
        t_elem inv_c1r2;
        t_elem inv_c2r0;
        t_elem inv_c2r1;
        t_elem inv_c2r2;
        logic  singular;
    } t_inv;

endpackage

[rtl/m3i_if.sv]
// ----------------------------------------------------------------------------
// m3i_if
// Valid/ready channels for input matrices and inverse results.
// ----------------------------------------------------------------------------
interface m3i_in_if;
    logic           valid;
    logic           ready;
    m3i_pkg::t_mat  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface m3i_out_if;
    logic           valid;
    logic           ready;
    m3i_pkg::t_inv  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/m3i_div_lane.sv]
// ----------------------------------------------------------------------------
// m3i_div_lane
// Pipelined restoring divider: one quotient bit per stage, MSB first.
// ----------------------------------------------------------------------------
module m3i_div_lane (
    input  logic                                i_clk,
    input  logic [m3i_pkg::DIV_STEPS-1:0]       i_en,
    input  logic [m3i_pkg::DMAG_W-1:0]          i_rem,
    input  logic [m3i_pkg::DMAG_W-1:0]          i_div,
    input  logic                                i_neg,
    input  logic                                i_ovf,
    output logic [m3i_pkg::DIV_STEPS-1:0]       o_quo,
    output logic                                o_neg,
    output logic                                o_ovf
);

    logic [m3i_pkg::DMAG_W-1:0]    r_rem [m3i_pkg::DIV_STEPS];
    logic [m3i_pkg::DMAG_W-1:0]    r_div [m3i_pkg::DIV_STEPS];
    logic [m3i_pkg::DIV_STEPS-1:0] r_quo [m3i_pkg::DIV_STEPS];
    logic                          r_neg [m3i_pkg::DIV_STEPS];
    logic                          r_ovf [m3i_pkg::DIV_STEPS];

    for (genvar j = 0; j < m3i_pkg::DIV_STEPS; j++) begin : g_step
        logic [m3i_pkg::DMAG_W-1:0]    rem_in;
        logic [m3i_pkg::DMAG_W-1:0]    div_in;
        logic [m3i_pkg::DIV_STEPS-1:0] quo_in;
        logic                          neg_in;
        logic                          ovf_in;
        logic [m3i_pkg::DMAG_W:0]      dbl;
        logic [m3i_pkg::DMAG_W:0]      diff;
        logic                          ge;

        if (j == 0) begin : g_head
            assign rem_in = i_rem;
            assign div_in = i_div;
            assign quo_in = '0;
            assign neg_in = i_neg;
            assign ovf_in = i_ovf;
        end else begin : g_body
            assign rem_in = r_rem[j-1];
            assign div_in = r_div[j-1];
            assign quo_in = r_quo[j-1];
            assign neg_in = r_neg[j-1];
            assign ovf_in = r_ovf[j-1];
        end

        // The remainder stays below the divisor, so doubling it needs one more bit.
        assign dbl  = {rem_in, 1'b0};
        assign diff = dbl - {1'b0, div_in};
        assign ge   = (dbl >= {1'b0, div_in});

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_rem[j] <= ge ? diff[m3i_pkg::DMAG_W-1:0] : dbl[m3i_pkg::DMAG_W-1:0];
                r_div[j] <= div_in;
                r_quo[j] <= {quo_in[m3i_pkg::DIV_STEPS-2:0], ge};
                r_neg[j] <= neg_in;
                r_ovf[j] <= ovf_in;
            end
        end
    end

    assign o_quo = r_quo[m3i_pkg::DIV_STEPS-1];
    assign o_neg = r_neg[m3i_pkg::DIV_STEPS-1];
    assign o_ovf = r_ovf[m3i_pkg::DIV_STEPS-1];

endmodule

[rtl/matrix3_inverse.sv]
// ----------------------------------------------------------------------------
// matrix3_inverse
// 3x3 matrix inverse by cofactors, signed Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
// The block takes one matrix per clock, unless a stalled result holds the
// pipeline, and returns its inverse: eight stages form the exact cofactors
// and determinant, 31 stages of nine parallel restoring dividers give one
// quotient bit each, and one stage rounds toward zero, saturates and
// registers the result. Every stage holds its beat when the stage after it
// is full and held, so empty stages keep filling while a result waits; the
// input is refused only when the whole pipeline is full. A matrix whose
// determinant magnitude is below det_threshold (register 0, Q16.16, reset
// 1) or exactly zero gives nine zeros and the singular flag. Write the
// threshold only while no matrix is in flight.
module matrix3_inverse (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    m3i_in_if.sink                        i_in,
    m3i_out_if.source                     o_out,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [m3i_pkg::APB_AW-1:0]    i_paddr,
    input  logic [m3i_pkg::APB_DW-1:0]    i_pwdata,
    output logic [m3i_pkg::APB_DW-1:0]    o_prdata,
    output logic                          o_pready
);

    localparam int NE = m3i_pkg::NUM_ELEM;
    localparam int NS = m3i_pkg::NUM_STAGES;
    localparam int DS = m3i_pkg::DIV_STEPS;
    localparam int DF = m3i_pkg::DIV_FIRST;

    // ---------------- configuration ----------------
    logic [m3i_pkg::THR_W-1:0] r_thr;

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == m3i_pkg::REG_DET_THR) ? {1'b0, r_thr} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= m3i_pkg::THR_RESET;
        end else if (i_psel && i_penable && i_pwrite && o_pready
                     && i_paddr[2] == m3i_pkg::REG_DET_THR) begin
            r_thr <= i_pwdata[m3i_pkg::THR_W-1:0];
        end
    end

    // ---------------- stage control ----------------
    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;

    always_comb begin
        en[NS-1] = !r_vld[NS-1] || o_out.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_in.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (en[k]) begin
                    r_vld[k] <= (k == 0) ? i_in.valid : r_vld[k-1];
                end
            end
        end
    end

    // ---------------- stage 0: input register ----------------
    m3i_pkg::t_elem m_in [NE];
    m3i_pkg::t_elem r_m0 [NE];

    assign m_in[0] = i_in.data.in_c0r0;
    assign m_in[1] = i_in.data.in_c0r1;
    assign m_in[2] = i_in.data.in_c0r2;
    assign m_in[3] = i_in.data.in_c1r0;
    assign m_in[4] = i_in.data.in_c1r1;
    assign m_in[5] = i_in.data.in_c1r2;
    assign m_in[6] = i_in.data.in_c2r0;
    assign m_in[7] = i_in.data.in_c2r1;
    assign m_in[8] = i_in.data.in_c2r2;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_m0 <= m_in;
        end
    end

    // ---------------- stage 1: cofactor products ----------------
    logic signed [m3i_pkg::PROD_W-1:0] r_pa [NE];
    logic signed [m3i_pkg::PROD_W-1:0] r_pb [NE];
    m3i_pkg::t_elem                    r_c1 [3];
    m3i_pkg::t_elem                    r_c2 [3];

    for (genvar k = 0; k < NE; k++) begin : g_prod
        always_ff @(posedge i_clk) begin
            if (en[1]) begin
                r_pa[k] <= r_m0[m3i_pkg::COF_IDX[k][0]] * r_m0[m3i_pkg::COF_IDX[k][1]];
                r_pb[k] <= r_m0[m3i_pkg::COF_IDX[k][2]] * r_m0[m3i_pkg::COF_IDX[k][3]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_c1 <= r_m0[0:2];
        end
        if (en[2]) begin
            r_c2 <= r_c1;
        end
    end

    // ---------------- stage 2: signed cofactors ----------------
    logic signed [m3i_pkg::COF_W-1:0] r_adj2 [NE];
    logic signed [m3i_pkg::COF_W-1:0] r_adj3 [NE];
    logic signed [m3i_pkg::COF_W-1:0] r_adj4 [NE];
    logic signed [m3i_pkg::COF_W-1:0] r_adj5 [NE];

    for (genvar k = 0; k < NE; k++) begin : g_cof
        logic [m3i_pkg::COF_W-1:0] ea;
        logic [m3i_pkg::COF_W-1:0] eb;
        assign ea = {r_pa[k][m3i_pkg::PROD_W-1], r_pa[k]};
        assign eb = {r_pb[k][m3i_pkg::PROD_W-1], r_pb[k]};
        always_ff @(posedge i_clk) begin
            if (en[2]) begin
                r_adj2[k] <= m3i_pkg::COF_NEG[k] ? (eb - ea) : (ea - eb);
            end
        end
    end

    // ---------------- stage 3: determinant partial products ----------------
    logic signed [m3i_pkg::PLO_W-1:0]   r_plo [3];
    logic signed [m3i_pkg::PHI_W-1:0]   r_phi [3];
    logic signed [m3i_pkg::PFULL_W-1:0] r_pf  [3];
    logic signed [m3i_pkg::DET_W-1:0]   r_det;

    for (genvar i = 0; i < 3; i++) begin : g_detp
        logic signed [m3i_pkg::LO_SPLIT:0]                lo_half;
        logic signed [m3i_pkg::COF_W-m3i_pkg::LO_SPLIT-1:0] hi_half;
        assign lo_half = {1'b0, r_adj2[3*i][m3i_pkg::LO_SPLIT-1:0]};
        assign hi_half = r_adj2[3*i][m3i_pkg::COF_W-1:m3i_pkg::LO_SPLIT];
        always_ff @(posedge i_clk) begin
            if (en[3]) begin
                r_plo[i] <= r_c2[i] * lo_half;
                r_phi[i] <= r_c2[i] * hi_half;
            end
            // Stage 4: recombine the halves into the full product.
            if (en[4]) begin
                r_pf[i] <= {r_phi[i], {m3i_pkg::LO_SPLIT{1'b0}}}
                         + {{(m3i_pkg::PFULL_W-m3i_pkg::PLO_W){r_plo[i][m3i_pkg::PLO_W-1]}},
                            r_plo[i]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_adj3 <= r_adj2;
        end
        if (en[4]) begin
            r_adj4 <= r_adj3;
        end
        // Stage 5: determinant.
        if (en[5]) begin
            r_adj5 <= r_adj4;
            r_det  <= {{2{r_pf[0][m3i_pkg::PFULL_W-1]}}, r_pf[0]}
                    + {{2{r_pf[1][m3i_pkg::PFULL_W-1]}}, r_pf[1]}
                    + {{2{r_pf[2][m3i_pkg::PFULL_W-1]}}, r_pf[2]};
        end
    end

    // ---------------- stage 6: magnitudes and signs ----------------
    logic [m3i_pkg::DMAG_W-1:0] r_dmag6;
    logic [m3i_pkg::CMAG_W-1:0] r_cmag6 [NE];
    logic [NE-1:0]              r_neg6;
    logic [m3i_pkg::DET_W-1:0]  det_abs;

    assign det_abs = r_det[m3i_pkg::DET_W-1] ? (~r_det + 1'b1) : r_det;

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_dmag6 <= det_abs[m3i_pkg::DMAG_W-1:0];
        end
    end

    for (genvar k = 0; k < NE; k++) begin : g_cabs
        logic [m3i_pkg::COF_W-1:0] cabs;
        assign cabs = r_adj5[k][m3i_pkg::COF_W-1] ? (~r_adj5[k] + 1'b1) : r_adj5[k];
        always_ff @(posedge i_clk) begin
            if (en[6]) begin
                r_cmag6[k] <= cabs[m3i_pkg::CMAG_W-1:0];
                r_neg6[k]  <= r_adj5[k][m3i_pkg::COF_W-1] ^ r_det[m3i_pkg::DET_W-1];
            end
        end
    end

    // ---------------- stage 7: threshold and overflow checks ----------------
    logic [m3i_pkg::DMAG_W-1:0] r_dmag7;
    logic [m3i_pkg::DMAG_W-1:0] r_rem7 [NE];
    logic [NE-1:0]              r_neg7;
    logic [NE-1:0]              r_ovf7;
    logic                       r_sing7;
    logic [m3i_pkg::DMAG_W-1:0] lim;

    assign lim = {{(m3i_pkg::DMAG_W-m3i_pkg::THR_W-m3i_pkg::THR_SHIFT){1'b0}},
                  r_thr, {m3i_pkg::THR_SHIFT{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_dmag7 <= r_dmag6;
            r_neg7  <= r_neg6;
            r_sing7 <= (r_dmag6 == '0) || (r_dmag6 < lim);
        end
    end

    // The quotient saturates once it reaches 2^31, which is when 2*|cof| >= |det|.
    for (genvar k = 0; k < NE; k++) begin : g_ovf
        logic [m3i_pkg::DMAG_W-1:0] rem0;
        assign rem0 = {{(m3i_pkg::DMAG_W-m3i_pkg::CMAG_W-1){1'b0}}, r_cmag6[k], 1'b0};
        always_ff @(posedge i_clk) begin
            if (en[7]) begin
                r_rem7[k] <= rem0;
                r_ovf7[k] <= (rem0 >= r_dmag6);
            end
        end
    end

    // ---------------- stages 8..38: division ----------------
    logic [DS-1:0] quo  [NE];
    logic [NE-1:0] qneg;
    logic [NE-1:0] qovf;
    logic          r_sing [DS];

    for (genvar k = 0; k < NE; k++) begin : g_lane
        m3i_div_lane u_lane (
            .i_clk (i_clk),
            .i_en  (en[DF +: DS]),
            .i_rem (r_rem7[k]),
            .i_div (r_dmag7),
            .i_neg (r_neg7[k]),
            .i_ovf (r_ovf7[k]),
            .o_quo (quo[k]),
            .o_neg (qneg[k]),
            .o_ovf (qovf[k])
        );
    end

    for (genvar j = 0; j < DS; j++) begin : g_sing
        always_ff @(posedge i_clk) begin
            if (en[DF+j]) begin
                r_sing[j] <= (j == 0) ? r_sing7 : r_sing[(j == 0) ? 0 : j-1];
            end
        end
    end

    // ---------------- stage 39: sign, saturation, output ----------------
    m3i_pkg::t_elem res [NE];
    m3i_pkg::t_inv  r_out;

    for (genvar k = 0; k < NE; k++) begin : g_fin
        logic [m3i_pkg::ELEM_W-1:0] q32;
        assign q32 = {1'b0, quo[k]};
        always_comb begin
            priority if (r_sing[DS-1]) begin
                res[k] = '0;
            end else if (qovf[k]) begin
                res[k] = qneg[k] ? m3i_pkg::SAT_NEG : m3i_pkg::SAT_POS;
            end else begin
                res[k] = qneg[k] ? (~q32 + 1'b1) : q32;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NS-1]) begin
            r_out.inv_c0r0 <= res[0];
            r_out.inv_c0r1 <= res[1];
            r_out.inv_c0r2 <= res[2];
            r_out.inv_c1r0 <= res[3];
            r_out.inv_c1r1 <= res[4];
            r_out.inv_c1r2 <= res[5];
            r_out.inv_c2r0 <= res[6];
            r_out.inv_c2r1 <= res[7];
            r_out.inv_c2r2 <= res[8];
            r_out.singular <= r_sing[DS-1];
        end
    end

    assign o_out.valid = r_vld[NS-1];
    assign o_out.data  = r_out;

endmodule

[rtl/m3i_checker.sv]
// ----------------------------------------------------------------------------
// m3i_checker
// Port-level checks on the inverse pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module m3i_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input m3i_pkg::t_inv i_out_data
);

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat valid right after reset");

    // With no result waiting nothing can hold the stages, so input is taken.
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input refused while no result is waiting");

    // A singular result carries an all-zero inverse.
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.singular) |->
            (i_out_data.inv_c0r0 == '0 && i_out_data.inv_c0r1 == '0 &&
             i_out_data.inv_c0r2 == '0 && i_out_data.inv_c1r0 == '0 &&
             i_out_data.inv_c1r1 == '0 && i_out_data.inv_c1r2 == '0 &&
             i_out_data.inv_c2r0 == '0 && i_out_data.inv_c2r1 == '0 &&
             i_out_data.inv_c2r2 == '0))
        else $error("singular beat with nonzero elements");

    // A stalled result beat stays and keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result beat dropped or changed");

endmodule

bind matrix3_inverse m3i_checker u_m3i_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
